/* design/satq_pkg.sv */
// Package with the types, constants and codes of the sorted alarm timer queue.
`default_nettype none

package satq_pkg;

    localparam int DEPTH  = 32;
    localparam int T_W    = 40;
    localparam int ID_W   = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADDR_W = PTR_W + 2;
    localparam int RAM_DEPTH = 4 * (2 ** PTR_W);

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    // Memory regions: the live queue and two scratch lists used while rebuilding it.
    localparam logic [1:0] REG_MAIN = 2'd0;
    localparam logic [1:0] REG_A    = 2'd1;
    localparam logic [1:0] REG_B    = 2'd2;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_ADJUST = 2'd3;

    localparam logic [2:0] KIND_FIRED    = 3'd0;
    localparam logic [2:0] KIND_ADDED    = 3'd1;
    localparam logic [2:0] KIND_REMOVED  = 3'd2;
    localparam logic [2:0] KIND_NOTFOUND = 3'd3;
    localparam logic [2:0] KIND_FULL     = 3'd4;
    localparam logic [2:0] KIND_CHECKED  = 3'd5;

    typedef struct packed {
        logic [1:0]            operation;
        logic [T_W-1:0]        new_expiry;
        logic                  is_calendar;
        logic [ID_W-1:0]       target_id;
        logic [T_W-1:0]        now_time;
        logic signed [T_W-1:0] time_delta;
    } satq_in_t;

    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] timer_id;
        logic [T_W-1:0]  alarm_expiry;
        logic            last;
    } satq_out_t;

    // One stored alarm; seq is its position before the rebuild, used to break ties.
    typedef struct packed {
        logic [T_W-1:0]   expiry;
        logic [ID_W-1:0]  id;
        logic             calendar;
        logic [CNT_W-1:0] seq;
    } satq_entry_t;

    localparam int ENTRY_W = $bits(satq_entry_t);

endpackage

`default_nettype wire

/* design/satq_ram.sv */
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module satq_ram #(
    parameter int DATA_W    = 8,
    parameter int MEM_DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(MEM_DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]            wdata,
    input  wire logic [$clog2(MEM_DEPTH)-1:0] raddr0,
    output logic      [DATA_W-1:0]            rdata0,
    input  wire logic [$clog2(MEM_DEPTH)-1:0] raddr1,
    output logic      [DATA_W-1:0]            rdata1
);

    logic [DATA_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

/* design/sorted_alarm_timer_queue.sv */
// Top level of the sorted alarm timer queue: control sequencer, output register, RAM.
//
//  channel | signals                        | payload
//  --------+--------------------------------+--------------------------------------
//  input   | in_valid, in_ready, in_data    | operation, expiry, flag, id, now, delta
//  output  | out_valid, out_ready, out_data | kind, alarm id, alarm expiry, last
//
// Every command rebuilds the queue in two passes over the RAM. The split pass
// reads the live entries once and copies them into scratch list A, or, on an
// adjust, calendar alarms into A and shifted relative alarms into B; a remove
// drops the alarm with the matching id, and an add first writes the new alarm into B.
// The merge pass reads both list heads, then decides, writes the merged order
// back and, except on a remove, sends due alarms out as fired transfers instead.
// A status transfer ends the command; the block stays busy until then, and
// longer while the output side stalls. Reset empties the queue and zeroes the
// id counter at once; no clearing pass is needed.
`default_nettype none

module sorted_alarm_timer_queue
    import satq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire satq_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output satq_out_t      out_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INS   = 3'd1;
    localparam logic [2:0] ST_SPLIT = 3'd2;
    localparam logic [2:0] ST_MRD   = 3'd3;
    localparam logic [2:0] ST_MDEC  = 3'd4;
    localparam logic [2:0] ST_STAT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [CNT_W-1:0]  rk_reg, rk_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  pseq_reg, pseq_next;
    logic [CNT_W-1:0]  na_reg, na_next;
    logic [CNT_W-1:0]  nb_reg, nb_next;
    logic [CNT_W-1:0]  pa_reg, pa_next;
    logic [CNT_W-1:0]  pb_reg, pb_next;
    logic [CNT_W-1:0]  wk_reg, wk_next;
    logic              found_reg, found_next;
    logic              full_reg, full_next;
    satq_in_t          cmd_reg, cmd_next;
    logic              out_valid_reg, out_valid_next;
    satq_out_t         out_reg, out_next;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr0, raddr1;
    satq_entry_t       wentry, rentry0, rentry1;
    logic [ENTRY_W-1:0] rdata0, rdata1;

    logic              slot_free;
    logic [T_W+1:0]    adj_sum;
    logic [T_W-1:0]    adj_exp;
    logic              a_ok, b_ok, take_a;
    satq_entry_t       sel;

    assign rentry0   = satq_entry_t'(rdata0);
    assign rentry1   = satq_entry_t'(rdata1);
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Shift of a relative alarm, saturating at zero and at the largest time.
    assign adj_sum = {2'b00, rentry0.expiry}
                   + {{2{cmd_reg.time_delta[T_W-1]}}, cmd_reg.time_delta};
    always_comb
    begin
        if (adj_sum[T_W+1])
        begin
            adj_exp = '0;
        end
        else if (adj_sum[T_W])
        begin
            adj_exp = T_MAX;
        end
        else
        begin
            adj_exp = adj_sum[T_W-1:0];
        end
    end

    // Merge choice: lower expiry first, equal expiry in the original queue order.
    assign a_ok   = (pa_reg < na_reg);
    assign b_ok   = (pb_reg < nb_reg);
    assign take_a = a_ok && (!b_ok || (rentry0.expiry < rentry1.expiry)
                    || ((rentry0.expiry == rentry1.expiry) && (rentry0.seq < rentry1.seq)));
    assign sel    = take_a ? rentry0 : rentry1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        rk_next        = rk_reg;
        pend_next      = 1'b0;
        pseq_next      = pseq_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        wk_next        = wk_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = {REG_MAIN, rk_reg[PTR_W-1:0]};
        wentry         = rentry0;
        raddr0         = {REG_MAIN, rk_reg[PTR_W-1:0]};
        raddr1         = {REG_B, pb_reg[PTR_W-1:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_data;
                    rk_next    = '0;
                    na_next    = '0;
                    nb_next    = '0;
                    pa_next    = '0;
                    pb_next    = '0;
                    wk_next    = '0;
                    found_next = 1'b0;
                    full_next  = (count_reg == CNT_W'(DEPTH));
                    if ((in_data.operation == OP_ADD) && (count_reg != CNT_W'(DEPTH)))
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        state_next = ST_SPLIT;
                    end
                end
            end

            ST_INS:
            begin
                // The new alarm ranks after every live entry of equal expiry.
                we              = 1'b1;
                waddr           = {REG_B, {PTR_W{1'b0}}};
                wentry.expiry   = cmd_reg.new_expiry;
                wentry.id       = next_id_reg;
                wentry.calendar = cmd_reg.is_calendar;
                wentry.seq      = count_reg;
                nb_next         = CNT_W'(1);
                next_id_next    = next_id_reg + ID_W'(1);
                state_next      = ST_SPLIT;
            end

            ST_SPLIT:
            begin
                if (rk_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    pseq_next = rk_reg;
                    rk_next   = rk_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    wentry.seq = pseq_reg;
                    if ((cmd_reg.operation == OP_REMOVE) && (rentry0.id == cmd_reg.target_id))
                    begin
                        found_next = 1'b1;
                    end
                    else if ((cmd_reg.operation == OP_ADJUST) && !rentry0.calendar)
                    begin
                        we            = 1'b1;
                        wentry.expiry = adj_exp;
                        waddr         = {REG_B, nb_reg[PTR_W-1:0]};
                        nb_next       = nb_reg + CNT_W'(1);
                    end
                    else
                    begin
                        we      = 1'b1;
                        waddr   = {REG_A, na_reg[PTR_W-1:0]};
                        na_next = na_reg + CNT_W'(1);
                    end
                end
                else if (rk_reg >= count_reg)
                begin
                    state_next = ST_MRD;
                end
            end

            ST_MRD:
            begin
                raddr0     = {REG_A, pa_reg[PTR_W-1:0]};
                raddr1     = {REG_B, pb_reg[PTR_W-1:0]};
                state_next = ST_MDEC;
            end

            ST_MDEC:
            begin
                // Keep both heads on the read ports so a stalled decision sees the same data.
                raddr0 = {REG_A, pa_reg[PTR_W-1:0]};
                raddr1 = {REG_B, pb_reg[PTR_W-1:0]};
                if (!a_ok && !b_ok)
                begin
                    state_next = ST_STAT;
                end
                else if ((cmd_reg.operation != OP_REMOVE) && (sel.expiry <= cmd_reg.now_time))
                begin
                    // A due alarm leaves through the output instead of going back.
                    if (slot_free)
                    begin
                        out_valid_next        = 1'b1;
                        out_next.kind         = KIND_FIRED;
                        out_next.timer_id     = sel.id;
                        out_next.alarm_expiry = sel.expiry;
                        out_next.last         = 1'b0;
                        if (take_a)
                        begin
                            pa_next = pa_reg + CNT_W'(1);
                        end
                        else
                        begin
                            pb_next = pb_reg + CNT_W'(1);
                        end
                        state_next = ST_MRD;
                    end
                end
                else
                begin
                    we      = 1'b1;
                    waddr   = {REG_MAIN, wk_reg[PTR_W-1:0]};
                    wentry  = sel;
                    wk_next = wk_reg + CNT_W'(1);
                    if (take_a)
                    begin
                        pa_next = pa_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pb_next = pb_reg + CNT_W'(1);
                    end
                    state_next = ST_MRD;
                end
            end

            ST_STAT:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.timer_id     = '0;
                    out_next.alarm_expiry = '0;
                    out_next.last         = 1'b1;
                    unique case (cmd_reg.operation)
                        OP_ADD:
                        begin
                            if (full_reg)
                            begin
                                out_next.kind = KIND_FULL;
                            end
                            else
                            begin
                                out_next.kind         = KIND_ADDED;
                                out_next.timer_id     = next_id_reg - ID_W'(1);
                                out_next.alarm_expiry = cmd_reg.new_expiry;
                            end
                        end
                        OP_REMOVE:
                        begin
                            out_next.kind = found_reg ? KIND_REMOVED : KIND_NOTFOUND;
                        end
                        default:
                        begin
                            out_next.kind = KIND_CHECKED;
                        end
                    endcase
                    count_next = wk_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            next_id_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg    <= rk_next;
        pseq_reg  <= pseq_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        wk_reg    <= wk_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        cmd_reg   <= cmd_next;
        out_reg   <= out_next;
    end

    satq_ram #(
        .DATA_W    (ENTRY_W),
        .MEM_DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (ENTRY_W'(wentry)),
        .raddr0 (raddr0),
        .rdata0 (rdata0),
        .raddr1 (raddr1),
        .rdata1 (rdata1)
    );

endmodule

`default_nettype wire
